@@ src/segi_pkg.sv @@
// Shared constants and types for the segment intersection core.
package segi_pkg;

    localparam int DEFAULT_COORD_BITS = 16;
    localparam int DEFAULT_FRAC_BITS  = 16;
    localparam int POINT_BITS         = 32;
    localparam int QUEUE_DEPTH        = 4;

    typedef struct packed {
        logic meet;
        logic point_ok;
    } segi_flags_t;

    localparam int FLAGS_BITS = $bits(segi_flags_t);

endpackage

@@ src/segi_pair_if.sv @@
// Stream interfaces for segment pair words and intersection result words.
interface segi_pair_if #(
    parameter int COORD_BITS = segi_pkg::DEFAULT_COORD_BITS
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] start_one_x;
    logic [COORD_BITS-1:0] start_one_y;
    logic [COORD_BITS-1:0] end_one_x;
    logic [COORD_BITS-1:0] end_one_y;
    logic [COORD_BITS-1:0] start_two_x;
    logic [COORD_BITS-1:0] start_two_y;
    logic [COORD_BITS-1:0] end_two_x;
    logic [COORD_BITS-1:0] end_two_y;

    modport source (
        output valid, start_one_x, start_one_y, end_one_x, end_one_y,
               start_two_x, start_two_y, end_two_x, end_two_y,
        input  ready
    );
    modport sink (
        input  valid, start_one_x, start_one_y, end_one_x, end_one_y,
               start_two_x, start_two_y, end_two_x, end_two_y,
        output ready
    );
endinterface

interface segi_result_if;
    logic                                valid;
    logic                                ready;
    logic                                segments_meet;
    logic                                point_valid;
    logic [segi_pkg::POINT_BITS-1:0]     meet_x;
    logic [segi_pkg::POINT_BITS-1:0]     meet_y;

    modport source (
        output valid, segments_meet, point_valid, meet_x, meet_y,
        input  ready
    );
    modport sink (
        input  valid, segments_meet, point_valid, meet_x, meet_y,
        output ready
    );
endinterface

@@ src/segment_intersection_core.sv @@
// Segment intersection core: one pair word in per cycle unless stalled, one result out.
// Each pair word gives segments AB and CD; the result says whether they touch or cross
// and, when they meet at a single determined point, gives that point in signed fixed
// point with FRAC_BITS fraction bits, truncated toward zero and kept to its low 32 bits.
// A new word is taken every cycle unless the front stalls on a full queue. Each pair
// passes through the six-stage front (products, meet test, weights, blend numerators)
// and the divider pipeline, which resolves one quotient bit per stage. A four-word
// queue sits between the two pipelines so that each can stall independently.
module segment_intersection_core #(
    parameter int COORD_BITS = segi_pkg::DEFAULT_COORD_BITS,
    parameter int FRAC_BITS  = segi_pkg::DEFAULT_FRAC_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    segi_pair_if.sink      pairs,
    segi_result_if.source  results
);
    localparam int WW   = 2 * (COORD_BITS + 1);
    localparam int DENW = WW + 1;
    localparam int NW   = COORD_BITS + WW + 1 + FRAC_BITS;
    localparam int EW   = segi_pkg::FLAGS_BITS + DENW + 2 * NW;

    logic                  q_push_valid, q_push_ready, q_pop_valid, q_pop;
    segi_pkg::segi_flags_t f_flags, b_flags;
    logic [DENW-1:0]       f_den, b_den;
    logic signed [NW-1:0]  f_num_x, f_num_y, b_num_x, b_num_y;
    logic [EW-1:0]         q_in, q_out;

    segi_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pairs      (pairs),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_flags (f_flags),
        .push_den   (f_den),
        .push_num_x (f_num_x),
        .push_num_y (f_num_y)
    );

    assign q_in = {f_flags, f_den, f_num_x, f_num_y};

    segi_queue #(
        .WIDTH (EW),
        .DEPTH (segi_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_in),
        .pop_valid  (q_pop_valid),
        .pop        (q_pop),
        .pop_data   (q_out)
    );

    assign {b_flags, b_den, b_num_x, b_num_y} = q_out;

    segi_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (q_pop_valid),
        .pop        (q_pop),
        .pop_flags  (b_flags),
        .pop_den    (b_den),
        .pop_num_x  (b_num_x),
        .pop_num_y  (b_num_y),
        .results    (results)
    );

`ifndef SYNTHESIS
    // A point is only reported for segments that meet.
    a_point_needs_meet: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.point_valid |-> results.segments_meet)
        else $error("point_valid without segments_meet");

    // Without a valid point both coordinates read zero.
    a_no_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.point_valid |-> results.meet_x == '0 && results.meet_y == '0)
        else $error("nonzero point fields without a valid point");

    // The front holds its word while the queue is full.
    a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
        q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_in))
        else $error("front dropped a word while the queue was full");

    // The back only pops when the queue holds a word.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_pop_valid)
        else $error("pop from an empty queue");
`endif

endmodule

@@ src/segi_front.sv @@
// Front pipeline: cross and dot products, meet test, weights and blend numerators.
module segi_front #(
    parameter int COORD_BITS = segi_pkg::DEFAULT_COORD_BITS,
    parameter int FRAC_BITS  = segi_pkg::DEFAULT_FRAC_BITS,
    localparam int CB   = COORD_BITS,
    localparam int DW   = CB + 1,
    localparam int PW   = 2 * DW,
    localparam int XW   = PW + 1,
    localparam int WW   = PW,
    localparam int DENW = WW + 1,
    localparam int NW0  = CB + WW + 1,
    localparam int NW   = NW0 + FRAC_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    segi_pair_if.sink              pairs,
    output logic                   push_valid,
    input  logic                   push_ready,
    output segi_pkg::segi_flags_t  push_flags,
    output logic [DENW-1:0]        push_den,
    output logic signed [NW-1:0]   push_num_x,
    output logic signed [NW-1:0]   push_num_y
);
    localparam int WH  = (WW + 1) / 2;
    localparam int WHH = WW - WH;
    localparam int PLW = CB + WH + 1;
    localparam int PHW = CB + WHH + 1;

    logic fe;

    // Stage 1: input coordinates
    logic                 v1_reg;
    logic signed [CB-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg, dx_reg, dy_reg;

    // Stage 2: products and point equalities
    logic                 v2_reg;
    logic signed [PW-1:0] prod_reg [24];
    logic signed [PW-1:0] prod_next [24];
    logic                 eq_ab_reg, eq_cd_reg, eq_ac_reg, eq_ad_reg, eq_bc_reg;
    logic signed [CB-1:0] cx2_reg, cy2_reg, dx2_reg, dy2_reg;

    // Stage 3: cross and dot sums
    logic                 v3_reg;
    logic signed [XW-1:0] cr_reg [4];
    logic signed [XW-1:0] dt_reg [8];
    logic                 eq3_ab_reg, eq3_cd_reg, eq3_ac_reg, eq3_ad_reg, eq3_bc_reg;
    logic signed [CB-1:0] cx3_reg, cy3_reg, dx3_reg, dy3_reg;

    // Stage 4: meet decision and weights
    logic                 v4_reg, meet4_reg;
    logic [WW-1:0]        wx4_reg, wy4_reg;
    logic signed [CB-1:0] cx4_reg, cy4_reg, dx4_reg, dy4_reg;

    // Stage 5: denominator and partial products
    logic                  v5_reg, meet5_reg;
    logic [DENW-1:0]       den5_reg;
    logic signed [PLW-1:0] pcx_l_reg, pdx_l_reg, pcy_l_reg, pdy_l_reg;
    logic signed [PHW-1:0] pcx_h_reg, pdx_h_reg, pcy_h_reg, pdy_h_reg;

    // Stage 6: queue-side register
    logic                  v6_reg;
    segi_pkg::segi_flags_t flags6_reg;
    logic [DENW-1:0]       den6_reg;
    logic signed [NW-1:0]  numx6_reg, numy6_reg;

    logic signed [DW-1:0] bax, bay, cax, cay, dax, day, abx, aby, cbx, cby, dbx, dby;
    logic signed [DW-1:0] dcx, dcy, acx, acy, bcx, bcy, cdx, cdy, adx, ady, bdx, bdy;
    logic onseg_abc, onseg_abd, onseg_cda, onseg_cdb, apart_ab, apart_cd, meet_next;
    logic signed [XW-1:0] cr0_abs, cr1_abs;
    logic signed [NW0-1:0] numx_next, numy_next;

    assign fe          = !v6_reg || push_ready;
    assign pairs.ready = fe;

    always_comb
    begin
        bax = DW'(bx_reg) - DW'(ax_reg);
        bay = DW'(by_reg) - DW'(ay_reg);
        cax = DW'(cx_reg) - DW'(ax_reg);
        cay = DW'(cy_reg) - DW'(ay_reg);
        dax = DW'(dx_reg) - DW'(ax_reg);
        day = DW'(dy_reg) - DW'(ay_reg);
        abx = DW'(ax_reg) - DW'(bx_reg);
        aby = DW'(ay_reg) - DW'(by_reg);
        cbx = DW'(cx_reg) - DW'(bx_reg);
        cby = DW'(cy_reg) - DW'(by_reg);
        dbx = DW'(dx_reg) - DW'(bx_reg);
        dby = DW'(dy_reg) - DW'(by_reg);
        dcx = DW'(dx_reg) - DW'(cx_reg);
        dcy = DW'(dy_reg) - DW'(cy_reg);
        acx = DW'(ax_reg) - DW'(cx_reg);
        acy = DW'(ay_reg) - DW'(cy_reg);
        bcx = DW'(bx_reg) - DW'(cx_reg);
        bcy = DW'(by_reg) - DW'(cy_reg);
        cdx = DW'(cx_reg) - DW'(dx_reg);
        cdy = DW'(cy_reg) - DW'(dy_reg);
        adx = DW'(ax_reg) - DW'(dx_reg);
        ady = DW'(ay_reg) - DW'(dy_reg);
        bdx = DW'(bx_reg) - DW'(dx_reg);
        bdy = DW'(by_reg) - DW'(dy_reg);

        // Cross products of (a,b,c), (a,b,d), (c,d,a), (c,d,b).
        prod_next[0]  = PW'(bax) * PW'(cay);
        prod_next[1]  = PW'(bay) * PW'(cax);
        prod_next[2]  = PW'(bax) * PW'(day);
        prod_next[3]  = PW'(bay) * PW'(dax);
        prod_next[4]  = PW'(dcx) * PW'(acy);
        prod_next[5]  = PW'(dcy) * PW'(acx);
        prod_next[6]  = PW'(dcx) * PW'(bcy);
        prod_next[7]  = PW'(dcy) * PW'(bcx);
        // Dot products that bound each point to the other segment's span.
        prod_next[8]  = PW'(bax) * PW'(cax);
        prod_next[9]  = PW'(bay) * PW'(cay);
        prod_next[10] = PW'(abx) * PW'(cbx);
        prod_next[11] = PW'(aby) * PW'(cby);
        prod_next[12] = PW'(bax) * PW'(dax);
        prod_next[13] = PW'(bay) * PW'(day);
        prod_next[14] = PW'(abx) * PW'(dbx);
        prod_next[15] = PW'(aby) * PW'(dby);
        prod_next[16] = PW'(dcx) * PW'(acx);
        prod_next[17] = PW'(dcy) * PW'(acy);
        prod_next[18] = PW'(cdx) * PW'(adx);
        prod_next[19] = PW'(cdy) * PW'(ady);
        prod_next[20] = PW'(dcx) * PW'(bcx);
        prod_next[21] = PW'(dcy) * PW'(bcy);
        prod_next[22] = PW'(cdx) * PW'(bdx);
        prod_next[23] = PW'(cdy) * PW'(bdy);
    end

    always_comb
    begin
        onseg_abc = eq3_ab_reg ? eq3_ac_reg :
                    (cr_reg[0] == '0 && !dt_reg[0][XW-1] && !dt_reg[1][XW-1]);
        onseg_abd = eq3_ab_reg ? eq3_ad_reg :
                    (cr_reg[1] == '0 && !dt_reg[2][XW-1] && !dt_reg[3][XW-1]);
        onseg_cda = eq3_cd_reg ? eq3_ac_reg :
                    (cr_reg[2] == '0 && !dt_reg[4][XW-1] && !dt_reg[5][XW-1]);
        onseg_cdb = eq3_cd_reg ? eq3_bc_reg :
                    (cr_reg[3] == '0 && !dt_reg[6][XW-1] && !dt_reg[7][XW-1]);
        apart_ab  = cr_reg[0] != '0 && cr_reg[1] != '0 &&
                    (cr_reg[0][XW-1] != cr_reg[1][XW-1]);
        apart_cd  = cr_reg[2] != '0 && cr_reg[3] != '0 &&
                    (cr_reg[2][XW-1] != cr_reg[3][XW-1]);
        meet_next = onseg_abc || onseg_abd || onseg_cda || onseg_cdb ||
                    (apart_ab && apart_cd);
        cr0_abs   = cr_reg[0][XW-1] ? -cr_reg[0] : cr_reg[0];
        cr1_abs   = cr_reg[1][XW-1] ? -cr_reg[1] : cr_reg[1];
    end

    always_comb
    begin
        numx_next = (NW0'(pcx_h_reg) <<< WH) + NW0'(pcx_l_reg)
                  + (NW0'(pdx_h_reg) <<< WH) + NW0'(pdx_l_reg);
        numy_next = (NW0'(pcy_h_reg) <<< WH) + NW0'(pcy_l_reg)
                  + (NW0'(pdy_h_reg) <<< WH) + NW0'(pdy_l_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (fe)
        begin
            v1_reg <= pairs.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            ax_reg <= $signed(pairs.start_one_x);
            ay_reg <= $signed(pairs.start_one_y);
            bx_reg <= $signed(pairs.end_one_x);
            by_reg <= $signed(pairs.end_one_y);
            cx_reg <= $signed(pairs.start_two_x);
            cy_reg <= $signed(pairs.start_two_y);
            dx_reg <= $signed(pairs.end_two_x);
            dy_reg <= $signed(pairs.end_two_y);

            prod_reg  <= prod_next;
            eq_ab_reg <= (ax_reg == bx_reg) && (ay_reg == by_reg);
            eq_cd_reg <= (cx_reg == dx_reg) && (cy_reg == dy_reg);
            eq_ac_reg <= (ax_reg == cx_reg) && (ay_reg == cy_reg);
            eq_ad_reg <= (ax_reg == dx_reg) && (ay_reg == dy_reg);
            eq_bc_reg <= (bx_reg == cx_reg) && (by_reg == cy_reg);
            cx2_reg   <= cx_reg;
            cy2_reg   <= cy_reg;
            dx2_reg   <= dx_reg;
            dy2_reg   <= dy_reg;

            for (int k = 0; k < 4; k++)
            begin
                cr_reg[k] <= XW'(prod_reg[2*k]) - XW'(prod_reg[2*k+1]);
            end
            for (int k = 0; k < 8; k++)
            begin
                dt_reg[k] <= XW'(prod_reg[8+2*k]) + XW'(prod_reg[9+2*k]);
            end
            eq3_ab_reg <= eq_ab_reg;
            eq3_cd_reg <= eq_cd_reg;
            eq3_ac_reg <= eq_ac_reg;
            eq3_ad_reg <= eq_ad_reg;
            eq3_bc_reg <= eq_bc_reg;
            cx3_reg    <= cx2_reg;
            cy3_reg    <= cy2_reg;
            dx3_reg    <= dx2_reg;
            dy3_reg    <= dy2_reg;

            meet4_reg <= meet_next;
            wx4_reg   <= cr0_abs[WW-1:0];
            wy4_reg   <= cr1_abs[WW-1:0];
            cx4_reg   <= cx3_reg;
            cy4_reg   <= cy3_reg;
            dx4_reg   <= dx3_reg;
            dy4_reg   <= dy3_reg;

            // Weights are split in halves so that each multiplier stays narrow.
            meet5_reg <= meet4_reg;
            den5_reg  <= DENW'(wx4_reg) + DENW'(wy4_reg);
            pcx_l_reg <= PLW'(cx4_reg) * PLW'($signed({1'b0, wy4_reg[WH-1:0]}));
            pcx_h_reg <= PHW'(cx4_reg) * PHW'($signed({1'b0, wy4_reg[WW-1:WH]}));
            pdx_l_reg <= PLW'(dx4_reg) * PLW'($signed({1'b0, wx4_reg[WH-1:0]}));
            pdx_h_reg <= PHW'(dx4_reg) * PHW'($signed({1'b0, wx4_reg[WW-1:WH]}));
            pcy_l_reg <= PLW'(cy4_reg) * PLW'($signed({1'b0, wy4_reg[WH-1:0]}));
            pcy_h_reg <= PHW'(cy4_reg) * PHW'($signed({1'b0, wy4_reg[WW-1:WH]}));
            pdy_l_reg <= PLW'(dy4_reg) * PLW'($signed({1'b0, wx4_reg[WH-1:0]}));
            pdy_h_reg <= PHW'(dy4_reg) * PHW'($signed({1'b0, wx4_reg[WW-1:WH]}));

            flags6_reg.meet     <= meet5_reg;
            flags6_reg.point_ok <= meet5_reg && (den5_reg != '0);
            den6_reg            <= den5_reg;
            numx6_reg           <= NW'(numx_next) <<< FRAC_BITS;
            numy6_reg           <= NW'(numy_next) <<< FRAC_BITS;
        end
    end

    assign push_valid = v6_reg;
    assign push_flags = flags6_reg;
    assign push_den   = den6_reg;
    assign push_num_x = numx6_reg;
    assign push_num_y = numy6_reg;

endmodule

@@ src/segi_queue.sv @@
// Short word queue between the front and back pipelines.
module segi_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = segi_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNTW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/segi_back.sv @@
// Back pipeline: one quotient bit per stage for both coordinates, then the result register.
module segi_back #(
    parameter int COORD_BITS = segi_pkg::DEFAULT_COORD_BITS,
    parameter int FRAC_BITS  = segi_pkg::DEFAULT_FRAC_BITS,
    localparam int CB   = COORD_BITS,
    localparam int WW   = 2 * (CB + 1),
    localparam int DENW = WW + 1,
    localparam int NW   = CB + WW + 1 + FRAC_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pop_valid,
    output logic                   pop,
    input  segi_pkg::segi_flags_t  pop_flags,
    input  logic [DENW-1:0]        pop_den,
    input  logic signed [NW-1:0]   pop_num_x,
    input  logic signed [NW-1:0]   pop_num_y,
    segi_result_if.source          results
);
    localparam int QB = CB + FRAC_BITS;
    localparam int OB = segi_pkg::POINT_BITS;
    localparam int RW = (QB + 1 > OB) ? QB + 1 : OB;

    logic be;

    logic                  v_reg     [QB+1];
    segi_pkg::segi_flags_t flags_reg [QB+1];
    logic [DENW-1:0]       den_reg   [QB+1];
    logic                  negx_reg  [QB+1];
    logic                  negy_reg  [QB+1];
    logic [DENW-1:0]       remx_reg  [QB+1];
    logic [DENW-1:0]       remy_reg  [QB+1];
    logic [QB-1:0]         lx_reg    [QB+1];
    logic [QB-1:0]         ly_reg    [QB+1];

    logic [NW-1:0]        magx, magy;
    logic signed [RW-1:0] resx, resy;

    logic                 out_valid_reg;
    logic                 out_meet_reg, out_pv_reg;
    logic [OB-1:0]        out_x_reg, out_y_reg;

    assign be  = !out_valid_reg || results.ready;
    assign pop = be && pop_valid;

    always_comb
    begin
        magx = pop_num_x[NW-1] ? NW'(-pop_num_x) : NW'(pop_num_x);
        magy = pop_num_y[NW-1] ? NW'(-pop_num_y) : NW'(pop_num_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (be)
        begin
            v_reg[0] <= pop_valid;
        end
    end

    // The top of the magnitude is already below the divisor, so only QB bits remain.
    always_ff @(posedge clk)
    begin
        if (be)
        begin
            flags_reg[0] <= pop_flags;
            den_reg[0]   <= pop_den;
            negx_reg[0]  <= pop_num_x[NW-1];
            negy_reg[0]  <= pop_num_y[NW-1];
            remx_reg[0]  <= magx[NW-1:QB];
            remy_reg[0]  <= magy[NW-1:QB];
            lx_reg[0]    <= magx[QB-1:0];
            ly_reg[0]    <= magy[QB-1:0];
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [DENW:0] tx, ty;
        logic          gex, gey;

        always_comb
        begin
            tx  = {remx_reg[k-1], lx_reg[k-1][QB-1]};
            ty  = {remy_reg[k-1], ly_reg[k-1][QB-1]};
            gex = tx >= {1'b0, den_reg[k-1]};
            gey = ty >= {1'b0, den_reg[k-1]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (be)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (be)
            begin
                flags_reg[k] <= flags_reg[k-1];
                den_reg[k]   <= den_reg[k-1];
                negx_reg[k]  <= negx_reg[k-1];
                negy_reg[k]  <= negy_reg[k-1];
                remx_reg[k]  <= gex ? DENW'(tx - {1'b0, den_reg[k-1]}) : tx[DENW-1:0];
                remy_reg[k]  <= gey ? DENW'(ty - {1'b0, den_reg[k-1]}) : ty[DENW-1:0];
                lx_reg[k]    <= {lx_reg[k-1][QB-2:0], gex};
                ly_reg[k]    <= {ly_reg[k-1][QB-2:0], gey};
            end
        end
    end

    always_comb
    begin
        resx = RW'($signed({1'b0, lx_reg[QB]}));
        resy = RW'($signed({1'b0, ly_reg[QB]}));
        if (negx_reg[QB])
        begin
            resx = -resx;
        end
        if (negy_reg[QB])
        begin
            resy = -resy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (be)
        begin
            out_valid_reg <= v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            out_meet_reg <= flags_reg[QB].meet;
            out_pv_reg   <= flags_reg[QB].point_ok;
            out_x_reg    <= flags_reg[QB].point_ok ? resx[OB-1:0] : '0;
            out_y_reg    <= flags_reg[QB].point_ok ? resy[OB-1:0] : '0;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.segments_meet = out_meet_reg;
    assign results.point_valid   = out_pv_reg;
    assign results.meet_x        = out_x_reg;
    assign results.meet_y        = out_y_reg;

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the segment intersection core.
`timescale 1ns / 100ps

module tb_top;

    localparam int CB = segi_pkg::DEFAULT_COORD_BITS;
    localparam int FB = segi_pkg::DEFAULT_FRAC_BITS;
    localparam int LATENCY = CB + FB + 8;

    typedef struct packed {
        logic [CB-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    } pair_word_t;

    typedef struct packed {
        logic        meet;
        logic        point_ok;
        logic [31:0] px;
        logic [31:0] py;
    } result_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    segi_pair_if #(.COORD_BITS(CB)) pairs ();
    segi_result_if results ();

    segment_intersection_core #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pairs   (pairs.sink),
        .results (results.source)
    );

    always #10 clk = ~clk;

    pair_word_t   pending_pairs[$];
    result_word_t expected_results[$];
    int           mismatches = 0;
    bit           stimulus_done = 0;
    int           hold_off = 0;
    bit           hold_done = 0;

    function automatic logic signed [63:0] cross3(logic signed [63:0] ox, oy, px, py, qx, qy);
        return (px - ox) * (qy - oy) - (py - oy) * (qx - ox);
    endfunction

    function automatic logic signed [63:0] dot3(logic signed [63:0] ox, oy, px, py, qx, qy);
        return (px - ox) * (qx - ox) + (py - oy) * (qy - oy);
    endfunction

    function automatic bit lies_on(logic signed [63:0] sx, sy, ex, ey, qx, qy);
        if (sx == ex && sy == ey)
            return sx == qx && sy == qy;
        return cross3(sx, sy, ex, ey, qx, qy) == 0 && dot3(sx, sy, ex, ey, qx, qy) >= 0
            && dot3(ex, ey, sx, sy, qx, qy) >= 0;
    endfunction

    function automatic bit straddles(logic signed [63:0] ax, ay, bx, by, cx, cy, dx, dy);
        logic signed [63:0] p, q;
        p = cross3(ax, ay, bx, by, cx, cy);
        q = cross3(ax, ay, bx, by, dx, dy);
        return (p > 0 && q < 0) || (p < 0 && q > 0);
    endfunction

    function automatic logic [31:0] weighted_point(logic signed [63:0] c0, w0, c1, w1, den);
        logic signed [127:0] num, quo;
        num = ((128'(c0) * 128'(w0)) + (128'(c1) * 128'(w1))) <<< FB;
        quo = num / 128'(den);
        return quo[31:0];
    endfunction

    function automatic result_word_t predict_meeting(pair_word_t w);
        result_word_t r;
        logic signed [63:0] ax, ay, bx, by, cx, cy, dx, dy, kc, kd, wc, wd;
        ax = 64'(signed'(w.ax)); ay = 64'(signed'(w.ay));
        bx = 64'(signed'(w.bx)); by = 64'(signed'(w.by));
        cx = 64'(signed'(w.cx)); cy = 64'(signed'(w.cy));
        dx = 64'(signed'(w.dx)); dy = 64'(signed'(w.dy));
        r = '0;
        r.meet = lies_on(ax, ay, bx, by, cx, cy) || lies_on(ax, ay, bx, by, dx, dy)
            || lies_on(cx, cy, dx, dy, ax, ay) || lies_on(cx, cy, dx, dy, bx, by)
            || (straddles(ax, ay, bx, by, cx, cy, dx, dy)
                && straddles(cx, cy, dx, dy, ax, ay, bx, by));
        if (r.meet)
        begin
            kc = cross3(ax, ay, bx, by, cx, cy);
            kd = cross3(ax, ay, bx, by, dx, dy);
            wc = kc < 0 ? -kc : kc;
            wd = kd < 0 ? -kd : kd;
            if (wc + wd != 0)
            begin
                r.point_ok = 1'b1;
                r.px = weighted_point(cx, wd, dx, wc, wc + wd);
                r.py = weighted_point(cy, wd, dy, wc, wc + wd);
            end
        end
        return r;
    endfunction

    function automatic logic [CB-1:0] rand_coord(int mode);
        case (mode)
            0: return CB'($urandom);
            1: return CB'($urandom_range(0, 15)) - CB'(8);
            default: return CB'($urandom_range(0, 200)) - CB'(100);
        endcase
    endfunction

    // Driver: each word waits a random number of idle cycles before it is offered.
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs.valid <= 1'b0;
            pairs.start_one_x <= '0; pairs.start_one_y <= '0;
            pairs.end_one_x <= '0;   pairs.end_one_y <= '0;
            pairs.start_two_x <= '0; pairs.start_two_y <= '0;
            pairs.end_two_x <= '0;   pairs.end_two_y <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (pairs.valid && pairs.ready)
            begin
                expected_results.push_back(predict_meeting({pairs.start_one_x,
                    pairs.start_one_y, pairs.end_one_x, pairs.end_one_y, pairs.start_two_x,
                    pairs.start_two_y, pairs.end_two_x, pairs.end_two_y}));
            end
            if (!pairs.valid || pairs.ready)
            begin
                if (send_gap > 0 || pending_pairs.size() == 0)
                begin
                    pairs.valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap <= send_gap - 1;
                end
                else
                begin
                    pair_word_t w;
                    w = pending_pairs.pop_front();
                    pairs.valid <= 1'b1;
                    pairs.start_one_x <= w.ax; pairs.start_one_y <= w.ay;
                    pairs.end_one_x <= w.bx;   pairs.end_one_y <= w.by;
                    pairs.start_two_x <= w.cx; pairs.start_two_y <= w.cy;
                    pairs.end_two_x <= w.dx;   pairs.end_two_y <= w.dy;
                    send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
                end
            end
        end
    end

    // Monitor: checks each accepted result word and draws the next stall.
    int recv_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result word meet=%0b", results.segments_meet);
                end
                else
                begin
                    result_word_t e;
                    e = expected_results.pop_front();
                    if (e.meet !== results.segments_meet || e.point_ok !== results.point_valid
                        || e.px !== results.meet_x || e.py !== results.meet_y)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected %0b %0b %h %h, got %0b %0b %h %h",
                                e.meet, e.point_ok, e.px, e.py, results.segments_meet,
                                results.point_valid, results.meet_x, results.meet_y);
                    end
                end
            end
            if (hold_off > 0)
                results.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                results.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                results.ready <= 1'b1;
                if (results.valid && results.ready)
                    recv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            end
        end
    end

    // Long receiver hold-off so that the pipeline and its queue fill up; the first one
    // is placed early in the random stream so that it always happens.
    always @(posedge clk)
    begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
        else if (rst_n && !hold_done && pending_pairs.size() < 600)
        begin
            hold_off <= 150;
            hold_done <= 1'b1;
        end
        else if (rst_n && !stimulus_done && $urandom_range(0, 2999) == 0)
            hold_off <= 150;
    end

    initial
    begin
        pair_word_t w;
        int mode;
        // Directed: crossing, touching, collinear overlap, points, extremes.
        pending_pairs.push_back({16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd0, 16'sd10,
            16'sd10, 16'sd0});
        pending_pairs.push_back({16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd5, 16'sd0,
            16'sd5, 16'sd7});
        pending_pairs.push_back({16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd5, 16'sd0,
            16'sd20, 16'sd0});
        pending_pairs.push_back({16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3,
            16'sd3, 16'sd3});
        pending_pairs.push_back({16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd0, 16'sd0,
            16'sd6, 16'sd6});
        pending_pairs.push_back({16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd4, 16'sd4,
            16'sd4, 16'sd4});
        pending_pairs.push_back({16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd1,
            16'sd10, 16'sd1});
        pending_pairs.push_back({16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
            16'h7fff, 16'h7fff, 16'h8000});
        pending_pairs.push_back({16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
            16'h8000, 16'h7fff, 16'h7fff});
        pending_pairs.push_back({16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
            16'hffff, 16'hffff, 16'hffff});
        pending_pairs.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
            16'h8000, 16'h7fff, 16'h7fff});
        pending_pairs.push_back({16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'sd1, 16'sd2,
            16'sd2, 16'hffff});
        for (int i = 0; i < 750; i++)
        begin
            mode = $urandom_range(0, 2);
            w = {rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
                 rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode)};
            // Some words reuse an endpoint so that touching cases are common.
            case ($urandom_range(0, 5))
                0: begin w.cx = w.ax; w.cy = w.ay; end
                1: begin w.dx = w.bx; w.dy = w.by; end
                2: begin w.bx = w.ax; w.by = w.ay; end
                default: ;
            endcase
            pending_pairs.push_back(w);
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_pairs.size() == 0 && !pairs.valid);
        stimulus_done = 1;
        wait (expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/segi_pkg.sv
src/segi_pair_if.sv
src/segi_front.sv
src/segi_queue.sv
src/segi_back.sv
src/segment_intersection_core.sv
sim/tb_top.sv
